FILE: design/bbc_pkg.sv
package bbc_pkg;

   // default number of openers the stack can hold
   localparam int StackDepthDefault = 128;

   // 2-bit opener / closer codes
   localparam logic [1:0] CodeRound  = 2'd0;
   localparam logic [1:0] CodeCurly  = 2'd1;
   localparam logic [1:0] CodeSquare = 2'd2;
   localparam logic [1:0] CodeNone   = 2'd3;

   // byte classes produced by the front end
   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_OPEN,
      KIND_CLOSE
   } kind_type;

   // verdict reason codes
   typedef enum logic [2:0] {
      FAIL_OK,
      FAIL_MISMATCH,
      FAIL_EMPTY,
      FAIL_UNCLOSED,
      FAIL_OVERFLOW
   } fail_type;

   // classified byte handed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [1:0] code;
      logic       last;
   } item_type;

endpackage

FILE: design/bbc_if.sv
// byte stream channel
interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// verdict channel
interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       balanced;
   logic [2:0] fail_reason;

   modport source (output valid, output balanced, output fail_reason, input ready);
   modport sink   (input valid, input balanced, input fail_reason, output ready);
endinterface

FILE: design/bracket_balance_checker_core.sv
// channel  | dir | transaction payload                      | handshake
// req_ch   | in  | char_code[7:0], last_char                | valid / ready
// rsp_ch   | out | balanced, fail_reason[2:0]               | valid / ready
//
// one byte per cycle sustained unless a last byte waits on a stalled verdict; the cached
// top-of-stack register and a registered next-to-top stack prefetch keep pops at full rate
// a verdict is offered from the output register once its last byte leaves the queue
// synchronous active-high reset clears depth, failure and queue; stack memory is not cleared
// a stalled verdict holds in the output register while the queue keeps taking bytes
module bracket_balance_checker_core #(
   parameter int StackDepth = bbc_pkg::StackDepthDefault
) (
   input  logic      clock,
   input  logic      reset,
   bbc_req_if.sink   req_ch,
   bbc_rsp_if.source rsp_ch
);
   import bbc_pkg::*;

   item_type front_item, queue_item;
   logic     front_valid, front_ready;
   logic     queue_valid, queue_ready;

   // byte classification
   bbc_front u_front (
      .req        (req_ch),
      .push_item  (front_item),
      .push_valid (front_valid),
      .push_ready (front_ready)
   );

   // decoupling queue
   bbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (front_item),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_item   (queue_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready)
   );

   // stack engine and verdict register
   bbc_back #(
      .StackDepth (StackDepth)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (queue_item),
      .pop_valid (queue_valid),
      .pop_ready (queue_ready),
      .rsp       (rsp_ch)
   );

endmodule

FILE: design/bbc_front.sv
module bbc_front (
   bbc_req_if.sink          req,
   output bbc_pkg::item_type push_item,
   output logic             push_valid,
   input  logic             push_ready
);
   import bbc_pkg::*;

   localparam logic [7:0] ChRoundOpen   = 8'h28;
   localparam logic [7:0] ChRoundClose  = 8'h29;
   localparam logic [7:0] ChCurlyOpen   = 8'h7b;
   localparam logic [7:0] ChCurlyClose  = 8'h7d;
   localparam logic [7:0] ChSquareOpen  = 8'h5b;
   localparam logic [7:0] ChSquareClose = 8'h5d;

   // classify the byte into opener, closer or other with its bracket code
   always_comb begin
      push_item.last = req.last_char;
      unique case (req.char_code)
         ChRoundOpen: begin
            push_item.kind = KIND_OPEN;
            push_item.code = CodeRound;
         end
         ChCurlyOpen: begin
            push_item.kind = KIND_OPEN;
            push_item.code = CodeCurly;
         end
         ChSquareOpen: begin
            push_item.kind = KIND_OPEN;
            push_item.code = CodeSquare;
         end
         ChRoundClose: begin
            push_item.kind = KIND_CLOSE;
            push_item.code = CodeRound;
         end
         ChCurlyClose: begin
            push_item.kind = KIND_CLOSE;
            push_item.code = CodeCurly;
         end
         ChSquareClose: begin
            push_item.kind = KIND_CLOSE;
            push_item.code = CodeSquare;
         end
         default: begin
            push_item.kind = KIND_OTHER;
            push_item.code = CodeNone;
         end
      endcase
   end

   // handshake passes straight to the queue
   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

FILE: design/bbc_queue.sv
module bbc_queue (
   input  logic              clock,
   input  logic              reset,
   input  bbc_pkg::item_type push_item,
   input  logic              push_valid,
   output logic              push_ready,
   output bbc_pkg::item_type pop_item,
   output logic              pop_valid,
   input  logic              pop_ready
);
   import bbc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // two-entry fifo, full rate when the back end drains every cycle
   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/bbc_back.sv
module bbc_back #(
   parameter int StackDepth = bbc_pkg::StackDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  bbc_pkg::item_type pop_item,
   input  logic              pop_valid,
   output logic              pop_ready,
   bbc_rsp_if.source         rsp
);
   import bbc_pkg::*;

   localparam int DepthWidth = $clog2(StackDepth + 1);
   localparam int AddrWidth  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
   localparam logic [DepthWidth-1:0] DepthMax = DepthWidth'(StackDepth);
   localparam logic [DepthWidth-1:0] DepthOne = DepthWidth'(1);
   localparam logic [DepthWidth-1:0] DepthTwo = DepthWidth'(2);

   logic [1:0]            stack_mem_ff [StackDepth];
   logic [1:0]            stack_rd_ff;
   logic [1:0]            top_ff, top_in;
   logic [DepthWidth-1:0] depth_ff, depth_in, depth_chk, rd_depth;
   fail_type              fail_ff, fail_in, fail_chk, reason;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  balanced_ff;
   fail_type              reason_ff;
   logic                  out_free, fire, do_check;
   logic                  is_push, is_pop, overflow, empty, mismatch;
   logic [AddrWidth-1:0]  wr_addr, rd_addr;

   // a non-last transaction never needs the output slot
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign pop_ready = !pop_item.last || out_free;
   assign fire      = pop_valid && pop_ready;
   assign do_check  = fire && (fail_ff == FAIL_OK);

   // stack operation decode against the cached top
   always_comb begin
      overflow = do_check && (pop_item.kind == KIND_OPEN) && (depth_ff == DepthMax);
      is_push  = do_check && (pop_item.kind == KIND_OPEN) && (depth_ff != DepthMax);
      empty    = do_check && (pop_item.kind == KIND_CLOSE) && (depth_ff == '0);
      is_pop   = do_check && (pop_item.kind == KIND_CLOSE) && (depth_ff != '0);
      mismatch = is_pop && (top_ff != pop_item.code);
   end

   // failure and depth after this byte
   always_comb begin
      priority if (overflow) begin
         fail_chk = FAIL_OVERFLOW;
      end else if (empty) begin
         fail_chk = FAIL_EMPTY;
      end else if (mismatch) begin
         fail_chk = FAIL_MISMATCH;
      end else begin
         fail_chk = fail_ff;
      end
      if (is_push) begin
         depth_chk = depth_ff + DepthOne;
      end else if (is_pop) begin
         depth_chk = depth_ff - DepthOne;
      end else begin
         depth_chk = depth_ff;
      end
   end

   // verdict on the last byte, then clear for the next string
   always_comb begin
      if (fail_chk != FAIL_OK) begin
         reason = fail_chk;
      end else if (depth_chk != '0) begin
         reason = FAIL_UNCLOSED;
      end else begin
         reason = FAIL_OK;
      end
      if (fire && pop_item.last) begin
         depth_in = '0;
         fail_in  = FAIL_OK;
      end else begin
         depth_in = depth_chk;
         fail_in  = fail_chk;
      end
      rsp_valid_in = (fire && pop_item.last) || (rsp_valid_ff && !rsp.ready);
   end

   // top-of-stack cache: a pop takes the prefetched next-to-top entry
   always_comb begin
      if (is_push) begin
         top_in = pop_item.code;
      end else if (is_pop) begin
         top_in = stack_rd_ff;
      end else begin
         top_in = top_ff;
      end
   end

   // prefetch address tracks the entry below the next top
   assign rd_depth = depth_in - DepthTwo;
   assign rd_addr  = rd_depth[AddrWidth-1:0];
   assign wr_addr  = depth_ff[AddrWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         fail_ff      <= FAIL_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (fire && pop_item.last) begin
         balanced_ff <= (reason == FAIL_OK);
         reason_ff   <= reason;
      end
   end

   // opener stack memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (is_push) begin
         stack_mem_ff[wr_addr] <= pop_item.code;
      end
      stack_rd_ff <= stack_mem_ff[rd_addr];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.balanced    = balanced_ff;
   assign rsp.fail_reason = reason_ff;

   // checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthMax)
      else $error("stack depth beyond capacity");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && pop_item.last |=> (depth_ff == '0) && (fail_ff == FAIL_OK) && rsp_valid_ff)
      else $error("state not cleared after verdict");

   a_verdict_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (balanced_ff == (reason_ff == FAIL_OK)))
      else $error("balanced flag disagrees with reason");

   a_failure_sticky: assert property (@(posedge clock) disable iff (reset)
      (fail_ff != FAIL_OK) && !(fire && pop_item.last) |=> $stable(fail_ff) && $stable(depth_ff))
      else $error("failure or depth changed after a failure");

endmodule

FILE: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import bbc_pkg::*;

   // bracket characters
   localparam logic [7:0] ChRoundOpen   = "(";
   localparam logic [7:0] ChRoundClose  = ")";
   localparam logic [7:0] ChCurlyOpen   = "{";
   localparam logic [7:0] ChCurlyClose  = "}";
   localparam logic [7:0] ChSquareOpen  = "[";
   localparam logic [7:0] ChSquareClose = "]";

   localparam int RandomItems = 750;
   localparam int HoldOffCycles = 400;
   localparam int HoldOffAfter = 25;
   localparam int PauseAtString = 50;
   localparam int DrainCycles = 20;

   typedef struct packed {
      logic     balanced;
      fail_type reason;
   } verdict_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      int         reps;
      bit         typed;
      logic       balanced;
      fail_type   reason;
   } stim_row_type;

   localparam int PlanRows = 27;

   // directed strings; typed verdicts only where they are obvious
   stim_row_type plan [0:PlanRows-1] = '{
      '{ChRoundOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChRoundClose,  1'b1, 1,   1'b1, 1'b1, FAIL_OK},
      '{8'h00,         1'b1, 1,   1'b1, 1'b1, FAIL_OK},
      '{8'hFF,         1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChSquareClose, 1'b1, 1,   1'b1, 1'b0, FAIL_EMPTY},
      '{ChRoundOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChCurlyClose,  1'b1, 1,   1'b1, 1'b0, FAIL_MISMATCH},
      '{ChSquareOpen,  1'b1, 1,   1'b1, 1'b0, FAIL_UNCLOSED},
      '{ChCurlyOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChSquareOpen,  1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChRoundOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChRoundClose,  1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChSquareClose, 1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChCurlyClose,  1'b1, 1,   1'b1, 1'b1, FAIL_OK},
      '{ChRoundClose,  1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChRoundOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChSquareClose, 1'b1, 1,   1'b1, 1'b0, FAIL_EMPTY},
      '{ChRoundOpen,   1'b0, 128, 1'b0, 1'b0, FAIL_OK},
      '{ChCurlyOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChRoundClose,  1'b1, 1,   1'b1, 1'b0, FAIL_OVERFLOW},
      '{ChSquareOpen,  1'b0, 128, 1'b0, 1'b0, FAIL_OK},
      '{ChSquareClose, 1'b0, 127, 1'b0, 1'b0, FAIL_OK},
      '{ChSquareClose, 1'b1, 1,   1'b1, 1'b1, FAIL_OK},
      '{8'hFF,         1'b1, 1,   1'b1, 1'b1, FAIL_OK},
      '{ChRoundOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChCurlyOpen,   1'b0, 1,   1'b0, 1'b0, FAIL_OK},
      '{ChSquareClose, 1'b1, 1,   1'b0, 1'b0, FAIL_OK}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   bbc_req_if req_ch ();
   bbc_rsp_if rsp_ch ();

   bracket_balance_checker_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   logic [1:0] nest_stack [StackDepthDefault];
   int         nest_depth;
   fail_type   first_failure;

   verdict_type verdict_q [$];
   logic [7:0]  text_q [$];
   int          errors;
   int          verdicts_seen;
   bit          tx_burst;
   bit          rx_burst;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // reset
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [1:0] opener_of(input logic [7:0] c);
      case (c)
         ChRoundOpen:  return CodeRound;
         ChCurlyOpen:  return CodeCurly;
         ChSquareOpen: return CodeSquare;
         default:      return CodeNone;
      endcase
   endfunction

   function automatic logic [1:0] closer_of(input logic [7:0] c);
      case (c)
         ChRoundClose:  return CodeRound;
         ChCurlyClose:  return CodeCurly;
         ChSquareClose: return CodeSquare;
         default:       return CodeNone;
      endcase
   endfunction

   function automatic logic [7:0] open_char(input logic [1:0] code);
      case (code)
         CodeRound: return ChRoundOpen;
         CodeCurly: return ChCurlyOpen;
         default:   return ChSquareOpen;
      endcase
   endfunction

   function automatic logic [7:0] close_char(input logic [1:0] code);
      case (code)
         CodeRound: return ChRoundClose;
         CodeCurly: return ChCurlyClose;
         default:   return ChSquareClose;
      endcase
   endfunction

   function automatic logic [7:0] random_bracket();
      logic [1:0] code;
      code = 2'($urandom_range(0, 2));
      return $urandom_range(0, 1) ? open_char(code) : close_char(code);
   endfunction

   // advance the bracket tracker by one byte; returns 1 with the verdict on a last byte
   function automatic bit predict_verdict(input logic [7:0] c, input logic last,
                                          output verdict_type v);
      logic [1:0] op;
      logic [1:0] cl;
      fail_type   why;
      op = opener_of(c);
      cl = closer_of(c);
      v = '0;
      if (first_failure == FAIL_OK) begin
         if (op != CodeNone) begin
            if (nest_depth >= StackDepthDefault) begin
               first_failure = FAIL_OVERFLOW;
            end else begin
               nest_stack[nest_depth] = op;
               nest_depth++;
            end
         end else if (cl != CodeNone) begin
            if (nest_depth == 0) begin
               first_failure = FAIL_EMPTY;
            end else begin
               nest_depth--;
               if (nest_stack[nest_depth] != cl) first_failure = FAIL_MISMATCH;
            end
         end
      end
      if (!last) return 1'b0;
      why = first_failure;
      if (why == FAIL_OK && nest_depth != 0) why = FAIL_UNCLOSED;
      v.balanced = (why == FAIL_OK);
      v.reason = why;
      nest_depth = 0;
      first_failure = FAIL_OK;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
   endtask

   // compare one accepted verdict with the oldest pending one
   task automatic check_verdict(input logic bal, input logic [2:0] why);
      verdict_type want;
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
         report_mismatch("verdict with none pending, reason", int'(why), -1);
      end else begin
         want = verdict_q.pop_front();
         if (bal !== want.balanced)
            report_mismatch("balanced", int'(bal), int'(want.balanced));
         if (why !== 3'(want.reason))
            report_mismatch("fail_reason", int'(why), int'(want.reason));
      end
   endtask

   // offer one byte and wait for its transaction
   task automatic send_byte(input logic [7:0] c, input logic last);
      int gap;
      if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
      gap = tx_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.char_code <= c;
      req_ch.last_char <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_tracked(input logic [7:0] c, input logic last);
      verdict_type v;
      send_byte(c, last);
      if (predict_verdict(c, last, v)) verdict_q.push_back(v);
   endtask

   // well-formed nesting with noise bytes mixed in; a noise byte can itself be a bracket
   task automatic fill_balanced(input int max_nest, input int len);
      logic [1:0] open_q [$];
      logic [1:0] code;
      int r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 9);
         if (r < 4 && open_q.size() < max_nest) begin
            code = 2'($urandom_range(0, 2));
            open_q.push_back(code);
            text_q.push_back(open_char(code));
         end else if (r < 8 && open_q.size() > 0) begin
            text_q.push_back(close_char(open_q.pop_back()));
         end else begin
            text_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      while (open_q.size() > 0) text_q.push_back(close_char(open_q.pop_back()));
   endtask

   // build the next random string into text_q
   task automatic build_string();
      int kind;
      int idx;
      int n;
      text_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         fill_balanced($urandom_range(1, 8), $urandom_range(0, 24));
      end else if (kind < 75) begin
         // broken well-formed string
         fill_balanced($urandom_range(1, 8), $urandom_range(1, 24));
         idx = $urandom_range(0, text_q.size() - 1);
         case ($urandom_range(0, 2))
            0:       text_q[idx] = random_bracket();
            1:       text_q.delete(idx);
            default: text_q.insert(idx, random_bracket());
         endcase
      end else if (kind < 85) begin
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 99) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) text_q.push_back(random_bracket());
      end else begin
         // deep nesting around the stack limit
         fill_balanced($urandom_range(StackDepthDefault - 8, StackDepthDefault + 8),
                       0);
         n = $urandom_range(StackDepthDefault - 8, StackDepthDefault + 8);
         begin
            logic [1:0] deep_q [$];
            logic [1:0] code;
            for (int i = 0; i < n; i++) begin
               code = 2'($urandom_range(0, 2));
               deep_q.push_back(code);
               text_q.push_back(open_char(code));
            end
            while (deep_q.size() > 0) text_q.push_back(close_char(deep_q.pop_back()));
         end
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // receiver side
   initial begin
      int gap;
      bit held;
      rsp_ch.ready <= 1'b0;
      held = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
         gap = rx_burst ? 0 : $urandom_range(0, 13);
         if (!held && verdicts_seen >= HoldOffAfter) begin
            gap = HoldOffCycles;
            held = 1'b1;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         check_verdict(rsp_ch.balanced, rsp_ch.fail_reason);
      end
   end

   // sender side and end of run
   initial begin
      verdict_type v;
      logic        last;
      int          sent;
      int          strings;
      req_ch.valid <= 1'b0;
      req_ch.char_code <= '0;
      req_ch.last_char <= 1'b0;
      nest_depth = 0;
      first_failure = FAIL_OK;
      errors = 0;
      verdicts_seen = 0;
      tx_burst = 1'b0;
      rx_burst = 1'b0;
      do @(posedge clock); while (reset);

      // directed strings
      for (int r = 0; r < PlanRows; r++) begin
         for (int k = 0; k < plan[r].reps; k++) begin
            last = (k == plan[r].reps - 1) ? plan[r].last : 1'b0;
            send_byte(plan[r].ch, last);
            if (predict_verdict(plan[r].ch, last, v)) begin
               if (plan[r].typed) begin
                  v.balanced = plan[r].balanced;
                  v.reason = plan[r].reason;
               end
               verdict_q.push_back(v);
            end
         end
      end

      // random strings
      sent = 0;
      strings = 0;
      while (sent < RandomItems) begin
         if (strings == PauseAtString) begin
            // let every pending verdict drain
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (verdict_q.size() != 0);
         end
         build_string();
         for (int i = 0; i < text_q.size(); i++) begin
            send_tracked(text_q[i], i == text_q.size() - 1);
            sent++;
         end
         strings++;
      end

      // drain
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (verdict_q.size() != 0);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
design/bbc_pkg.sv
design/bbc_if.sv
design/bbc_front.sv
design/bbc_queue.sv
design/bbc_back.sv
design/bracket_balance_checker_core.sv
verif/testbench.sv
